// ----- hdl/hessenberg_givens_qr_column_macros.svh -----
// assertion macros used by the hessenberg givens qr column controller
`ifndef HESSENBERG_GIVENS_QR_COLUMN_MACROS_SVH
`define HESSENBERG_GIVENS_QR_COLUMN_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define HGQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgq check failed");

// next-cycle implication, checked at every clock edge out of reset
`define HGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgq check failed");

`endif

// ----- hdl/hgq_pkg.sv -----
// types and constants of the hessenberg givens qr column block
package hgq_pkg;

    localparam int CNT_BITS = 6;
    localparam logic [CNT_BITS-1:0] CNT_MAX = 6'd63;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam int DIV_STEPS = 31;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ROT_LD,
        ST_ROT_ONE,
        ST_SETUP,
        ST_DIV,
        ST_SQ,
        ST_SQ_LD,
        ST_SQRT,
        ST_INV_LD,
        ST_INV,
        ST_OM,
        ST_ROT_SET,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_P6,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_C_CV,
        MUL_S_E,
        MUL_NS_CV,
        MUL_C_E,
        MUL_C_RES,
        MUL_NS_RES,
        MUL_TT,
        MUL_TI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_RV,
        CAP_NC,
        CAP_RE,
        CAP_RN
    } cap_t;

    typedef struct packed {
        logic     accept;
        logic     take_row0;
        logic     rot_mem;
        logic     rot_one;
        logic     div_tm;
        logic     div_inv;
        logic     div_step;
        logic     latch_tm;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     rot_set;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        cap_t     cap;
        logic     commit;
    } hgq_cmd_t;

    typedef struct packed {
        logic col_end;
        logic row_zero;
        logic dy_zero;
        logic out_free;
    } hgq_status_t;

endpackage

// ----- hdl/hgq_entry_if.sv -----
// input channel: one hessenberg column entry per beat
interface hgq_entry_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] entry_value;
    logic               column_end;
    logic               new_system;

    modport source (output valid, entry_value, column_end, new_system, input ready);
    modport sink (input valid, entry_value, column_end, new_system, output ready);
endinterface

// ----- hdl/hgq_result_if.sv -----
// output channel: one finished triangular entry per beat
interface hgq_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rotated_value;
    logic [4:0]         row_number;
    logic               column_done;
    logic signed [31:0] rotation_cosine;
    logic signed [31:0] rotation_sine;
    logic signed [31:0] residual_entry;
    logic signed [31:0] residual_next;
    logic               saturated;

    modport source (output valid, rotated_value, row_number, column_done, rotation_cosine,
                    rotation_sine, residual_entry, residual_next, saturated, input ready);
    modport sink (input valid, rotated_value, row_number, column_done, rotation_cosine,
                  rotation_sine, residual_entry, residual_next, saturated, output ready);
endinterface

// ----- hdl/hgq_datapath.sv -----
// datapath: rotation stores, shared multiplier, divider, square root, output register
module hgq_datapath
    import hgq_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int WORD_BITS   = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    input  logic signed [31:0] entry_value,
    input  logic               column_end,
    input  logic               new_system,
    input  hgq_cmd_t           cmd,
    output hgq_status_t        status,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [31:0] rotated_value,
    output logic [4:0]         row_number,
    output logic               column_done,
    output logic signed [31:0] rotation_cosine,
    output logic signed [31:0] rotation_sine,
    output logic signed [31:0] residual_entry,
    output logic signed [31:0] residual_next,
    output logic               saturated
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int VB = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam logic signed [33:0] SAT_HI = 34'sd2 ** (VB - 1) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -(34'sd2 ** (VB - 1));

    // round a q30-scaled sum to q16.16 (add half, floor) and saturate; msb is the clip flag
    function automatic logic [32:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [33:0] sh;
        logic [32:0]        r;
        t  = v + 64'sd536870912;
        sh = 34'(t >>> 30);
        if (sh > SAT_HI) begin
            r = {1'b1, SAT_HI[31:0]};
        end else if (sh < SAT_LO) begin
            r = {1'b1, SAT_LO[31:0]};
        end else begin
            r = {1'b0, sh[31:0]};
        end
        return r;
    endfunction

    // rotation stores
    logic signed [31:0] cos_mem [MAX_COLUMNS];
    logic signed [31:0] sin_mem [MAX_COLUMNS];
    logic signed [31:0] rd_cos_reg;
    logic signed [31:0] rd_sin_reg;
    logic               rd_ok_reg;

    logic [30:0]        init_res_reg;
    logic signed [31:0] ent_reg;
    logic               col_end_reg;
    logic signed [31:0] cv_reg;
    logic signed [31:0] res_reg;
    logic [CNT_BITS-1:0] row_reg;
    logic [CNT_BITS-1:0] col_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [30:0]        quo_reg;
    logic [30:0]        tm_reg;
    logic [63:0]        sq_n_reg;
    logic [63:0]        sq_res_reg;
    logic [63:0]        sq_bit_reg;
    logic               dy_big_reg;
    logic               neg_reg;
    logic signed [31:0] rv_reg;
    logic signed [31:0] nc_reg;
    logic signed [31:0] re_reg;
    logic signed [31:0] rn_reg;
    logic               clip_reg;

    logic               out_valid_reg;
    logic signed [31:0] o_rv_reg;
    logic [4:0]         o_row_reg;
    logic               o_done_reg;
    logic signed [31:0] o_cos_reg;
    logic signed [31:0] o_sin_reg;
    logic signed [31:0] o_re_reg;
    logic signed [31:0] o_rn_reg;
    logic               o_sat_reg;

    // store addressing
    logic [CNT_BITS-1:0]    rd_idx;
    logic [CNT_BITS+AW-1:0] rd_wide;
    logic [CNT_BITS+AW-1:0] wr_wide;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   rd_in_range;
    logic                   wr_in_range;
    logic                   mem_we;

    assign rd_idx      = row_reg - 6'd1;
    assign rd_wide     = {{AW{1'b0}}, rd_idx};
    assign wr_wide     = {{AW{1'b0}}, col_reg};
    assign rd_addr     = rd_wide[AW-1:0];
    assign wr_addr     = wr_wide[AW-1:0];
    assign rd_in_range = 32'(rd_idx) < MAX_COLUMNS;
    assign wr_in_range = 32'(col_reg) < MAX_COLUMNS;
    assign mem_we      = cmd.commit && col_end_reg && wr_in_range;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cos_mem[wr_addr] <= c_reg;
            sin_mem[wr_addr] <= s_reg;
        end
        rd_cos_reg <= cos_mem[rd_addr];
        rd_sin_reg <= sin_mem[rd_addr];
    end

    // rotation setup operands
    logic [32:0] ax_w;
    logic [32:0] ay_w;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        dy_big;

    assign ax_w   = cv_reg[31] ? 33'(-{cv_reg[31], cv_reg}) : {1'b0, cv_reg};
    assign ay_w   = ent_reg[31] ? 33'(-{ent_reg[31], ent_reg}) : {1'b0, ent_reg};
    assign ax     = ax_w[31:0];
    assign ay     = ay_w[31:0];
    assign dy_big = ay > ax;

    // divider step
    logic        div_ge;
    logic [33:0] div_sub;

    assign div_ge  = rem_reg >= {2'b00, den_reg};
    assign div_sub = div_ge ? (rem_reg - {2'b00, den_reg}) : rem_reg;

    // square root step
    logic [63:0] sq_try;
    logic        sq_ge;

    assign sq_try = sq_res_reg + sq_bit_reg;
    assign sq_ge  = sq_n_reg >= sq_try;

    // shared multiplier operand select
    logic signed [31:0] ma;
    logic signed [31:0] mb;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul_sel)
            MUL_C_CV:   begin ma = c_reg;             mb = cv_reg;            end
            MUL_S_E:    begin ma = s_reg;             mb = ent_reg;           end
            MUL_NS_CV:  begin ma = -s_reg;            mb = cv_reg;            end
            MUL_C_E:    begin ma = c_reg;             mb = ent_reg;           end
            MUL_C_RES:  begin ma = c_reg;             mb = res_reg;           end
            MUL_NS_RES: begin ma = -s_reg;            mb = res_reg;           end
            MUL_TT:     begin ma = {1'b0, quo_reg};   mb = {1'b0, quo_reg};   end
            MUL_TI:     begin ma = {1'b0, tm_reg};    mb = {1'b0, quo_reg};   end
            default:    begin ma = '0;                mb = '0;                end
        endcase
    end

    // rounding of the accumulator
    logic [32:0] rnd;
    assign rnd = round_sat(acc_reg);

    // finished rotation from the reciprocal
    logic [31:0]        om;
    logic signed [31:0] other;
    logic signed [31:0] inv_s;

    assign om    = prod_reg[61:30];
    assign other = neg_reg ? -$signed(om) : $signed(om);
    assign inv_s = {1'b0, quo_reg};

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ent_reg     <= entry_value;
            col_end_reg <= column_end;
        end
        rd_ok_reg <= rd_in_range;
        if (cmd.rot_mem)
        begin
            c_reg <= rd_ok_reg ? rd_cos_reg : '0;
            s_reg <= rd_ok_reg ? rd_sin_reg : '0;
        end else if (cmd.rot_one)
        begin
            c_reg <= ONE_Q30;
            s_reg <= '0;
        end else if (cmd.rot_set)
        begin
            c_reg <= dy_big_reg ? other : inv_s;
            s_reg <= dy_big_reg ? inv_s : other;
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= ma * mb;
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:  acc_reg <= acc_reg;
        endcase
        case (cmd.cap)
            CAP_RV:  rv_reg <= rnd[31:0];
            CAP_NC:  nc_reg <= rnd[31:0];
            CAP_RE:  re_reg <= rnd[31:0];
            CAP_RN:  rn_reg <= rnd[31:0];
            default: ;
        endcase
        // divider: quotient of a * 2^30 / b with a <= b
        if (cmd.div_tm)
        begin
            dy_big_reg <= dy_big;
            neg_reg    <= cv_reg[31] ^ ent_reg[31];
            rem_reg    <= {2'b00, dy_big ? ax : ay};
            den_reg    <= dy_big ? ay : ax;
            quo_reg    <= '0;
        end else if (cmd.div_inv)
        begin
            rem_reg <= {2'b00, 32'h4000_0000};
            den_reg <= sq_res_reg[31:0];
            quo_reg <= '0;
        end else if (cmd.div_step)
        begin
            rem_reg <= {div_sub[32:0], 1'b0};
            quo_reg <= {quo_reg[29:0], div_ge};
        end
        if (cmd.latch_tm)
        begin
            tm_reg <= quo_reg;
        end
        // square root, two bits per step
        if (cmd.sqrt_init)
        begin
            sq_n_reg   <= 64'h1000_0000_0000_0000 + 64'(prod_reg);
            sq_res_reg <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end else if (cmd.sqrt_step)
        begin
            if (sq_ge)
            begin
                sq_n_reg   <= sq_n_reg - sq_try;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // configuration and system state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_res_reg <= 31'd65536;
            cv_reg       <= '0;
            res_reg      <= 32'sd65536;
            row_reg      <= '0;
            col_reg      <= '0;
            clip_reg     <= 1'b0;
        end else
        begin
            if (cfg_we)
            begin
                init_res_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                clip_reg <= 1'b0;
                if (new_system)
                begin
                    cv_reg  <= '0;
                    res_reg <= {1'b0, init_res_reg};
                    row_reg <= '0;
                    col_reg <= '0;
                end
            end else if (cmd.cap != CAP_NONE)
            begin
                clip_reg <= clip_reg | rnd[32];
            end
            if (cmd.take_row0)
            begin
                cv_reg  <= ent_reg;
                row_reg <= 6'd1;
            end
            if (cmd.commit)
            begin
                if (col_end_reg)
                begin
                    res_reg <= rn_reg;
                    cv_reg  <= '0;
                    row_reg <= '0;
                    if (col_reg != CNT_MAX)
                    begin
                        col_reg <= col_reg + 6'd1;
                    end
                end else
                begin
                    cv_reg <= nc_reg;
                    if (row_reg != CNT_MAX)
                    begin
                        row_reg <= row_reg + 6'd1;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            o_rv_reg   <= rv_reg;
            o_row_reg  <= col_end_reg ? col_reg[4:0] : rd_idx[4:0];
            o_done_reg <= col_end_reg;
            o_cos_reg  <= col_end_reg ? c_reg : '0;
            o_sin_reg  <= col_end_reg ? s_reg : '0;
            o_re_reg   <= col_end_reg ? re_reg : '0;
            o_rn_reg   <= col_end_reg ? rn_reg : '0;
            o_sat_reg  <= clip_reg;
        end
    end

    assign status.col_end  = col_end_reg;
    assign status.row_zero = row_reg == '0;
    assign status.dy_zero  = ent_reg == '0;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign rotated_value   = o_rv_reg;
    assign row_number      = o_row_reg;
    assign column_done     = o_done_reg;
    assign rotation_cosine = o_cos_reg;
    assign rotation_sine   = o_sin_reg;
    assign residual_entry  = o_re_reg;
    assign residual_next   = o_rn_reg;
    assign saturated       = o_sat_reg;

endmodule

// ----- hdl/hgq_controller.sv -----
// controller: sequences one entry through the datapath
module hgq_controller
    import hgq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hgq_status_t status,
    output hgq_cmd_t    cmd
);

`include "hessenberg_givens_qr_column_macros.svh"

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.col_end)
                begin
                    state_next = status.dy_zero ? ST_ROT_ONE : ST_SETUP;
                end else if (status.row_zero)
                begin
                    cmd.take_row0 = 1'b1;
                    state_next    = ST_IDLE;
                end else
                begin
                    state_next = ST_ROT_LD;
                end
            end
            ST_ROT_LD:
            begin
                cmd.rot_mem = 1'b1;
                state_next  = ST_P1;
            end
            ST_ROT_ONE:
            begin
                cmd.rot_one = 1'b1;
                state_next  = ST_P1;
            end
            ST_SETUP:
            begin
                cmd.div_tm = 1'b1;
                cnt_next   = 5'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.mul_sel  = MUL_TT;
                cmd.latch_tm = 1'b1;
                state_next   = ST_SQ_LD;
            end
            ST_SQ_LD:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = 5'(SQRT_STEPS - 1);
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_INV_LD;
                end
            end
            ST_INV_LD:
            begin
                cmd.div_inv = 1'b1;
                cnt_next    = 5'(DIV_STEPS - 1);
                state_next  = ST_INV;
            end
            ST_INV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_OM;
                end
            end
            ST_OM:
            begin
                cmd.mul_sel = MUL_TI;
                state_next  = ST_ROT_SET;
            end
            ST_ROT_SET:
            begin
                cmd.rot_set = 1'b1;
                state_next  = ST_P1;
            end
            // rotate the pair: first output then second half
            ST_P1:
            begin
                cmd.mul_sel = MUL_C_CV;
                state_next  = ST_P2;
            end
            ST_P2:
            begin
                cmd.mul_sel = MUL_S_E;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_P3;
            end
            ST_P3:
            begin
                cmd.mul_sel = status.col_end ? MUL_C_RES : MUL_NS_CV;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_P4;
            end
            ST_P4:
            begin
                cmd.mul_sel = status.col_end ? MUL_NS_RES : MUL_C_E;
                cmd.acc_op  = ACC_LOAD;
                cmd.cap     = CAP_RV;
                state_next  = ST_P5;
            end
            ST_P5:
            begin
                if (status.col_end)
                begin
                    cmd.acc_op = ACC_LOAD;
                    cmd.cap    = CAP_RE;
                end else
                begin
                    cmd.acc_op = ACC_ADD;
                end
                state_next = ST_P6;
            end
            ST_P6:
            begin
                cmd.cap    = status.col_end ? CAP_RN : CAP_NC;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `HGQ_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, status.out_free)
    `HGQ_ASSERT_NEXT(a_accept_decide, clk, rst_n, in_valid && in_ready, state_reg == ST_DECIDE)
    `HGQ_ASSERT_NEXT(a_p6_done, clk, rst_n, state_reg == ST_P6, state_reg == ST_DONE)
    `HGQ_ASSERT_NOW(a_busy_no_accept, clk, rst_n, state_reg != ST_IDLE, !cmd.accept)

endmodule

// ----- hdl/hessenberg_givens_qr_column.sv -----
// Givens QR update of a Hessenberg matrix, one column entry per input beat.
// An ordinary entry goes from acceptance to its result through a store
// read, four products through the one shared 32x32 multiplier and two
// roundings. The last entry of a column first sets up its rotation with the
// bit-serial divider (31 steps, run twice, for the ratio and the reciprocal)
// and the two-bits-per-step square root (32 steps). A zero last entry skips
// the rotation setup. The first entry of a column gives no result beat,
// unless it also ends the column. One entry is in work at a time, and the
// next entry can be taken in the cycle after a result is written. A finished
// result waits in the output register while the next entry is taken. No
// clearing pass follows reset.
module hessenberg_givens_qr_column
    import hgq_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int WORD_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    hgq_entry_if.sink   entry,
    hgq_result_if.source result
);

    hgq_cmd_t    cmd;
    hgq_status_t status;
    logic        in_ready;

    assign entry.ready = in_ready;

    // sequencing
    hgq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (entry.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    hgq_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .entry_value     (entry.entry_value),
        .column_end      (entry.column_end),
        .new_system      (entry.new_system),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .rotated_value   (result.rotated_value),
        .row_number      (result.row_number),
        .column_done     (result.column_done),
        .rotation_cosine (result.rotation_cosine),
        .rotation_sine   (result.rotation_sine),
        .residual_entry  (result.residual_entry),
        .residual_next   (result.residual_next),
        .saturated       (result.saturated)
    );

endmodule
